[rtl/bfra_pkg.sv]
package bfra_pkg;

	localparam int unsigned OFS_W = 32;
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned ST_W = 3;
	localparam int unsigned ALIGN_BYTES = 64;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 3'd0,
		ST_OOM    = 3'd1,
		ST_ZERO   = 3'd2,
		ST_FULL   = 3'd3,
		ST_BADREL = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0,
		REG_BASE     = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_ALLOC,
		S_SHIFT_UP,
		S_SPLIT,
		S_DROP,
		S_MERGE_NEXT,
		S_MERGE_PREV,
		S_REMOVE,
		S_PUSH,
		S_REPORT,
		S_OUT
	} state_t;

endpackage

[rtl/best_fit_region_allocator_core.sv]
// Best-fit heap allocator over an address-ordered region table held in flip-flops.
// One request at a time: the input is not ready while a request is worked on or its result beat
// waits on the output. One small sequencer walks the table one entry a cycle. An allocation
// scans the table, then runs either the rank pass of an exact fit or the shift of a split; a
// release that merges both neighbours scans, then runs two rank passes, two removal shifts and
// the push to the front of the free order. Zero-size, oversized and out-of-range requests
// answer the cycle after acceptance. A stall on m_tready holds the result beat on the output.
// After reset and after a heap_capacity write, a clearing pass over all MAX_REGIONS entries
// rebuilds the table as one free region; configuration writes are taken only while idle.
module best_fit_region_allocator_core #(
	parameter int unsigned MAX_REGIONS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_bytes, release_address (from bit 0)
	input  logic [95:0]  s_tdata,
	// operation
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// granted_address, granted_bytes (from bit 0)
	output logic [95:0]  m_tdata,
	// status
	output logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import bfra_pkg::*;

	localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
	localparam logic [OFS_W:0] ALIGN_M1 = (OFS_W+1)'(ALIGN_BYTES - 1);

	logic [OFS_W-1:0] ofs_q [MAX_REGIONS];
	logic [OFS_W-1:0] len_q [MAX_REGIONS];
	logic [CNT_W-1:0] rank_q [MAX_REGIONS];
	logic [MAX_REGIONS-1:0] free_q;
	logic [CNT_W-1:0] count_q;

	logic [OFS_W-1:0]  cap_q;
	logic [ADDR_W-1:0] base_q;

	state_t state_q, state_d;
	logic [CNT_W-1:0] j_q;
	logic [IDX_W-1:0] t_q;
	logic [CNT_W-1:0] r_q;
	logic found_q;
	logic op_q;
	logic [OFS_W-1:0] size_q;
	logic [OFS_W-1:0] off_q;
	logic [OFS_W-1:0] blen_q;
	logic [CNT_W-1:0] brank_q;
	logic merged_q;
	logic [ST_W-1:0]   st_q;
	logic [ADDR_W-1:0] oaddr_q;
	logic [OFS_W-1:0]  obytes_q;

	logic in_op;
	logic [OFS_W-1:0] in_req;
	logic [ADDR_W-1:0] in_addr;
	logic [OFS_W:0] aligned;
	logic [ADDR_W-1:0] rel_off;
	logic [IDX_W-1:0] j_idx;
	logic [IDX_W-1:0] j_next;
	logic [IDX_W-1:0] t_next;
	logic [IDX_W-1:0] t_prev;
	logic nxt_merge;
	logic prv_merge;

	assign in_op = s_tuser[0];
	assign in_req = s_tdata[31:0];
	assign in_addr = s_tdata[95:32];
	assign aligned = ({1'b0, in_req} + ALIGN_M1) & ~((OFS_W+1)'(ALIGN_BYTES - 1));
	assign rel_off = in_addr - base_q;
	assign j_idx = j_q[IDX_W-1:0];
	assign j_next = j_idx + IDX_W'(1);
	assign t_next = t_q + IDX_W'(1);
	assign t_prev = t_q - IDX_W'(1);
	assign nxt_merge = (CNT_W'(t_q) + CNT_W'(1) < count_q) && free_q[t_next];
	assign prv_merge = (t_q != '0) && free_q[t_prev];

	assign s_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {obytes_q, oaddr_q};
	assign m_tuser = st_q;

	logic last_j;
	assign last_j = (j_q + CNT_W'(1) >= count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid && cfg_index == REG_CAPACITY)
					state_d = S_INIT;
				else if (s_tvalid && s_tready) begin
					if (in_op == OP_ALLOC && (in_req == '0 || aligned[OFS_W]))
						state_d = S_OUT;
					else if (in_op == OP_RELEASE && rel_off[ADDR_W-1:OFS_W] != '0)
						state_d = S_OUT;
					else
						state_d = S_SCAN;
				end
			end
			S_INIT:       if (j_q == CNT_W'(MAX_REGIONS - 1)) state_d = S_IDLE;
			S_SCAN: begin
				if (op_q == OP_RELEASE) begin
					if (free_q[j_idx] == 1'b0 && ofs_q[j_idx] == off_q)
						state_d = S_MERGE_NEXT;
					else if (last_j)
						state_d = S_OUT;
				end else if (last_j)
					state_d = S_ALLOC;
			end
			S_ALLOC: begin
				if (!found_q)
					state_d = S_OUT;
				else if (blen_q == size_q)
					state_d = S_DROP;
				else if (count_q >= CNT_W'(MAX_REGIONS))
					state_d = S_OUT;
				else
					state_d = S_SHIFT_UP;
			end
			S_SHIFT_UP:   if (j_q <= CNT_W'(t_q) + CNT_W'(1)) state_d = S_SPLIT;
			S_SPLIT:      state_d = S_REPORT;
			S_DROP:       if (last_j) state_d = (op_q == OP_ALLOC) ? S_REPORT : S_REMOVE;
			S_MERGE_NEXT: state_d = nxt_merge ? S_DROP : S_MERGE_PREV;
			S_MERGE_PREV: state_d = prv_merge ? S_DROP : S_PUSH;
			S_REMOVE:     if (last_j) state_d = merged_q ? S_MERGE_PREV : S_PUSH;
			S_PUSH:       if (last_j) state_d = S_REPORT;
			S_REPORT:     state_d = S_OUT;
			S_OUT:        if (m_tready) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_INIT;
		else
			state_q <= state_d;
	end

	// merged_q: set while the upper neighbour is dropped and taken out of the table

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 32'd1048576;
			base_q <= '0;
			j_q <= '0;
			count_q <= CNT_W'(1);
			free_q <= '0;
			t_q <= '0;
			found_q <= 1'b0;
			merged_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					j_q <= '0;
					found_q <= 1'b0;
					merged_q <= 1'b0;
					if (cfg_valid) begin
						if (cfg_index == REG_CAPACITY)
							cap_q <= cfg_data[OFS_W-1:0];
						else
							base_q <= cfg_data;
					end else if (s_tvalid) begin
						op_q <= in_op;
						size_q <= aligned[OFS_W-1:0];
						off_q <= rel_off[OFS_W-1:0];
						oaddr_q <= '0;
						obytes_q <= '0;
						if (in_op == OP_ALLOC)
							st_q <= (in_req == '0) ? ST_ZERO : ST_OOM;
						else
							st_q <= ST_BADREL;
					end
				end
				S_INIT: begin
					ofs_q[j_idx] <= '0;
					len_q[j_idx] <= (j_q == '0) ? cap_q : '0;
					rank_q[j_idx] <= '0;
					free_q[j_idx] <= (j_q == '0);
					count_q <= CNT_W'(1);
					j_q <= (j_q == CNT_W'(MAX_REGIONS - 1)) ? '0 : j_q + CNT_W'(1);
				end
				S_SCAN: begin
					if (op_q == OP_RELEASE) begin
						if (free_q[j_idx] == 1'b0 && ofs_q[j_idx] == off_q)
							t_q <= j_idx;
					end else if (free_q[j_idx] && len_q[j_idx] >= size_q &&
							(!found_q || len_q[j_idx] < blen_q ||
							(len_q[j_idx] == blen_q && rank_q[j_idx] < brank_q))) begin
						found_q <= 1'b1;
						t_q <= j_idx;
						blen_q <= len_q[j_idx];
						brank_q <= rank_q[j_idx];
					end
					j_q <= j_q + CNT_W'(1);
				end
				S_ALLOC: begin
					r_q <= brank_q;
					if (found_q && blen_q == size_q) begin
						free_q[t_q] <= 1'b0;
						rank_q[t_q] <= '0;
						j_q <= '0;
					end else if (found_q && count_q >= CNT_W'(MAX_REGIONS))
						st_q <= ST_FULL;
					else
						j_q <= count_q;
				end
				S_SHIFT_UP: begin
					ofs_q[j_idx] <= ofs_q[j_idx - IDX_W'(1)];
					len_q[j_idx] <= len_q[j_idx - IDX_W'(1)];
					rank_q[j_idx] <= rank_q[j_idx - IDX_W'(1)];
					free_q[j_idx] <= free_q[j_idx - IDX_W'(1)];
					j_q <= j_q - CNT_W'(1);
				end
				S_SPLIT: begin
					count_q <= count_q + CNT_W'(1);
					len_q[t_q] <= size_q;
					free_q[t_q] <= 1'b0;
					rank_q[t_q] <= '0;
					ofs_q[t_next] <= ofs_q[t_q] + size_q;
					len_q[t_next] <= len_q[t_q] - size_q;
				end
				S_DROP: begin
					if (free_q[j_idx] && rank_q[j_idx] > r_q)
						rank_q[j_idx] <= rank_q[j_idx] - CNT_W'(1);
					j_q <= last_j ? (merged_q ? CNT_W'(t_next) : CNT_W'(t_q)) : j_q + CNT_W'(1);
				end
				S_MERGE_NEXT: begin
					j_q <= '0;
					if (nxt_merge) begin
						len_q[t_q] <= len_q[t_q] + len_q[t_next];
						merged_q <= 1'b1;
						r_q <= rank_q[t_next];
						free_q[t_next] <= 1'b0;
						rank_q[t_next] <= '0;
					end
				end
				S_MERGE_PREV: begin
					j_q <= '0;
					if (prv_merge) begin
						len_q[t_prev] <= len_q[t_prev] + len_q[t_q];
						r_q <= rank_q[t_prev];
						free_q[t_prev] <= 1'b0;
						rank_q[t_prev] <= '0;
					end
				end
				S_REMOVE: begin
					if (last_j) begin
						ofs_q[j_idx] <= '0;
						len_q[j_idx] <= '0;
						rank_q[j_idx] <= '0;
						free_q[j_idx] <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						merged_q <= 1'b0;
						if (!merged_q)
							t_q <= t_prev;
						j_q <= '0;
					end else begin
						ofs_q[j_idx] <= ofs_q[j_next];
						len_q[j_idx] <= len_q[j_next];
						rank_q[j_idx] <= rank_q[j_next];
						free_q[j_idx] <= free_q[j_next];
						j_q <= j_q + CNT_W'(1);
					end
				end
				S_PUSH: begin
					if (free_q[j_idx])
						rank_q[j_idx] <= rank_q[j_idx] + CNT_W'(1);
					if (last_j) begin
						free_q[t_q] <= 1'b1;
						rank_q[t_q] <= '0;
					end
					j_q <= j_q + CNT_W'(1);
				end
				S_REPORT: begin
					st_q <= ST_OK;
					oaddr_q <= base_q + ADDR_W'(ofs_q[t_q]);
					obytes_q <= len_q[t_q];
				end
				S_OUT: ;
				default: ;
			endcase
		end
	end

	property p_out_held;
		@(posedge clk) disable iff (!arst_n)
			m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
	endproperty
	a_out_held: assert property (p_out_held) else $error("result beat changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(1) && count_q <= CNT_W'(MAX_REGIONS) || state_q == S_INIT)
		else $error("region count out of range");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st_q == ST_OK && op_q == OP_ALLOC |-> obytes_q != '0)
		else $error("granted zero bytes");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("took a beat while busy");
endmodule

[test/tb_top.sv]
module tb_top;
	import bfra_pkg::*;

	localparam int unsigned NREG = 32;
	localparam int unsigned GRAIN = 64;
	localparam int unsigned RAND_ITEMS = 500;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct {
		op_t         op;
		bit [31:0]   req;
		bit [63:0]   rel;
	} request_t;

	typedef struct {
		status_t     st;
		bit [63:0]   addr;
		bit [31:0]   len;
	} grant_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [63:0]  cfg_data;

	request_t  pending[$];
	request_t  in_flight;
	grant_t    grants_due[$];
	bit [63:0] live_addrs[$];
	int unsigned s_idle_pct;
	int unsigned r_idle_pct;
	int unsigned stall_cycles;
	bit          failed;

	bit [31:0]   heap_cap;
	bit [63:0]   heap_org;
	bit [31:0]   rg_off[NREG];
	bit [31:0]   rg_len[NREG];
	bit          rg_free[NREG];
	int unsigned rg_rank[NREG];
	int unsigned rg_cnt;

	best_fit_region_allocator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic void table_clear();
		for (int j = 0; j < NREG; j++) begin
			rg_off[j] = '0;
			rg_len[j] = '0;
			rg_free[j] = 1'b0;
			rg_rank[j] = 0;
		end
		rg_len[0] = heap_cap;
		rg_free[0] = 1'b1;
		rg_cnt = 1;
		live_addrs.delete();
	endfunction

	function automatic void drop_rank(int unsigned k);
		int unsigned r;
		r = rg_rank[k];
		rg_free[k] = 1'b0;
		rg_rank[k] = 0;
		for (int unsigned j = 0; j < rg_cnt; j++)
			if (rg_free[j] && rg_rank[j] > r)
				rg_rank[j]--;
	endfunction

	function automatic void link_front(int unsigned k);
		rg_free[k] = 1'b0;
		for (int unsigned j = 0; j < rg_cnt; j++)
			if (rg_free[j])
				rg_rank[j]++;
		rg_free[k] = 1'b1;
		rg_rank[k] = 0;
	endfunction

	function automatic void squeeze_out(int unsigned k);
		for (int unsigned j = k; j + 1 < rg_cnt; j++) begin
			rg_off[j] = rg_off[j+1];
			rg_len[j] = rg_len[j+1];
			rg_free[j] = rg_free[j+1];
			rg_rank[j] = rg_rank[j+1];
		end
		rg_cnt--;
		rg_off[rg_cnt] = '0;
		rg_len[rg_cnt] = '0;
		rg_free[rg_cnt] = 1'b0;
		rg_rank[rg_cnt] = 0;
	endfunction

	function automatic grant_t pick_fit(bit [31:0] req);
		grant_t g;
		bit [32:0] rounded;
		bit [31:0] need;
		int unsigned best;
		bit found;
		g = '{ST_OK, 64'd0, 32'd0};
		best = 0;
		found = 1'b0;
		if (req == 0) begin
			g.st = ST_ZERO;
			return g;
		end
		rounded = ({1'b0, req} + 33'd63) & ~33'd63;
		if (rounded[32]) begin
			g.st = ST_OOM;
			return g;
		end
		need = rounded[31:0];
		for (int unsigned j = 0; j < rg_cnt; j++) begin
			if (!rg_free[j] || rg_len[j] < need)
				continue;
			if (!found || rg_len[j] < rg_len[best] ||
			    (rg_len[j] == rg_len[best] && rg_rank[j] < rg_rank[best])) begin
				best = j;
				found = 1'b1;
			end
		end
		if (!found) begin
			g.st = ST_OOM;
			return g;
		end
		if (rg_len[best] == need) begin
			drop_rank(best);
		end else begin
			if (rg_cnt >= NREG) begin
				g.st = ST_FULL;
				return g;
			end
			for (int unsigned j = rg_cnt; j > best; j--) begin
				rg_off[j] = rg_off[j-1];
				rg_len[j] = rg_len[j-1];
				rg_free[j] = rg_free[j-1];
				rg_rank[j] = rg_rank[j-1];
			end
			rg_cnt++;
			rg_len[best] = need;
			rg_free[best] = 1'b0;
			rg_rank[best] = 0;
			rg_off[best+1] += need;
			rg_len[best+1] -= need;
		end
		g.addr = heap_org + 64'(rg_off[best]);
		g.len = need;
		live_addrs.push_back(g.addr);
		return g;
	endfunction

	function automatic grant_t give_back(bit [63:0] address);
		grant_t g;
		bit [63:0] off;
		int unsigned t;
		bit found;
		g = '{ST_BADREL, 64'd0, 32'd0};
		off = address - heap_org;
		t = 0;
		found = 1'b0;
		if (off[63:32] != 0)
			return g;
		for (int unsigned j = 0; j < rg_cnt; j++)
			if (rg_off[j] == off[31:0] && !rg_free[j]) begin
				t = j;
				found = 1'b1;
				break;
			end
		if (!found)
			return g;
		if (t + 1 < rg_cnt && rg_free[t+1]) begin
			rg_len[t] += rg_len[t+1];
			drop_rank(t + 1);
			squeeze_out(t + 1);
		end
		if (t > 0 && rg_free[t-1]) begin
			rg_len[t-1] += rg_len[t];
			drop_rank(t - 1);
			squeeze_out(t);
			t--;
		end
		link_front(t);
		g.st = ST_OK;
		g.addr = heap_org + 64'(rg_off[t]);
		g.len = rg_len[t];
		foreach (live_addrs[i])
			if (live_addrs[i] == address) begin
				live_addrs.delete(i);
				break;
			end
		return g;
	endfunction

	function automatic void predict_grant(request_t rq);
		if (rq.op == OP_ALLOC)
			grants_due.push_back(pick_fit(rq.req));
		else
			grants_due.push_back(give_back(rq.rel));
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_grant(in_flight);
			if ((!s_tvalid || s_tready) ) begin
				if (pending.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
					in_flight = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {in_flight.rel, in_flight.req};
					s_tuser <= in_flight.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					$error("unexpected result beat %h %h", m_tuser, m_tdata);
					failed = 1'b1;
				end else begin
					grant_t g;
					g = grants_due.pop_front();
					if (m_tuser !== g.st) begin
						$error("status: expected %0d, got %0d", g.st, m_tuser);
						failed = 1'b1;
					end
					if (m_tdata[63:0] !== g.addr) begin
						$error("granted_address: expected %h, got %h", g.addr, m_tdata[63:0]);
						failed = 1'b1;
					end
					if (m_tdata[95:64] !== g.len) begin
						$error("granted_bytes: expected %h, got %h", g.len, m_tdata[95:64]);
						failed = 1'b1;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= r_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		             (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("best_fit_region_allocator_core test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_req(op_t op, bit [31:0] req, bit [63:0] rel);
		pending.push_back('{op, req, rel});
	endtask

	task automatic quiesce();
		while (pending.size() > 0 || s_tvalid || grants_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, bit [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_CAPACITY) begin
			heap_cap = val[31:0];
			table_clear();
		end else begin
			heap_org = val;
		end
	endtask

	task automatic random_burst(int unsigned n, bit hold_once);
		bit [31:0] sz;
		bit [63:0] ad;
		int unsigned roll;
		int unsigned lim;
		for (int unsigned i = 0; i < n; i++) begin
			while (pending.size() > 1)
				@(posedge clk);
			if (hold_once && i == n / 2)
				while (pending.size() > 0 || s_tvalid || grants_due.size() > 0)
					@(posedge clk);
			roll = $urandom_range(99);
			lim = (heap_cap / 16 > 0) ? heap_cap / 16 : 1;
			ad = {$urandom, $urandom};
			if (roll < 55 || live_addrs.size() == 0) begin
				roll = $urandom_range(99);
				if (roll < 70)
					sz = $urandom_range(lim, 1);
				else if (roll < 85)
					sz = $urandom_range(8, 1) * GRAIN;
				else
					sz = $urandom;
				add_req(OP_ALLOC, sz, ad);
			end else begin
				roll = $urandom_range(99);
				if (roll < 85)
					ad = live_addrs[$urandom_range(live_addrs.size() - 1)];
				else if (roll < 92)
					ad = live_addrs[0] + GRAIN;
				add_req(OP_RELEASE, $urandom, ad);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_idle_pct = 24;
		r_idle_pct = 70;
		failed = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		heap_cap = 32'd1048576;
		heap_org = '0;
		table_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// default heap: sizes, rounding, exact fit, merges, bad releases
		add_req(OP_ALLOC, 32'd0, 64'd0);
		add_req(OP_ALLOC, 32'd1, 64'd0);
		add_req(OP_ALLOC, 32'd65, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OP_ALLOC, 32'hFFFF_FFFF, 64'd0);
		add_req(OP_ALLOC, 32'hFFFF_FFC1, 64'd0);
		add_req(OP_ALLOC, 32'hFFFF_FFC0, 64'd0);
		add_req(OP_ALLOC, 32'd1048576 - 192, 64'd0);
		add_req(OP_ALLOC, 32'd64, 64'd0);
		add_req(OP_RELEASE, 32'hFFFF_FFFF, 64'd0);
		add_req(OP_RELEASE, 32'd0, 64'd0);
		add_req(OP_RELEASE, 32'd0, 64'd1);
		add_req(OP_RELEASE, 32'd0, 64'h1_0000_0000);
		add_req(OP_RELEASE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		add_req(OP_RELEASE, 32'd0, 64'd64);
		add_req(OP_ALLOC, 32'd64, 64'd0);
		add_req(OP_ALLOC, 32'd64, 64'd0);
		add_req(OP_RELEASE, 32'd0, 64'd0);
		add_req(OP_RELEASE, 32'd0, 64'd192);
		add_req(OP_RELEASE, 32'd0, 64'd64);
		add_req(OP_ALLOC, 32'd128, 64'd0);
		random_burst(RAND_ITEMS, 1'b0);
		quiesce();

		write_reg(REG_CAPACITY, 64'd64);
		write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFC0);
		random_burst(RAND_ITEMS, 1'b0);
		quiesce();

		s_idle_pct = 70;
		r_idle_pct = 24;
		write_reg(REG_CAPACITY, 64'hFFFF_FFFF);
		write_reg(REG_BASE, {$urandom, $urandom});
		random_burst(RAND_ITEMS, 1'b1);
		quiesce();

		s_idle_pct = 0;
		r_idle_pct = 0;
		write_reg(REG_CAPACITY, 64'd4096);
		write_reg(REG_BASE, 64'h1000);
		random_burst(RAND_ITEMS, 1'b0);
		quiesce();

		if (!failed)
			$display("best_fit_region_allocator_core test passed");
		else
			$display("best_fit_region_allocator_core test failed");
		$finish;
	end
endmodule

[sim.f]
rtl/bfra_pkg.sv
rtl/best_fit_region_allocator_core.sv
test/tb_top.sv
